>>> src/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants for the binary max-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Command handed from the front part to the back part.
  typedef struct packed {
    op_t         op;
    logic [31:0] value;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH_RD,
    S_PUSH_CMP,
    S_POP_RD_LAST,
    S_POP_WR_ROOT,
    S_POP_RD_KIDS,
    S_POP_WAIT,
    S_POP_CMP,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_TOP_RD,
    S_TOP_WAIT,
    S_DONE
  } state_t;

endpackage

>>> src/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read through registered port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/bmhq_front.sv
// ----------------------------------------------------------------------------
// bmhq_front
// Accepts input beats and queues them as commands for the back part.
// ----------------------------------------------------------------------------
module bmhq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_value,
  output logic               cmd_valid,
  input  logic               cmd_take,
  output bmhq_pkg::cmd_t     cmd
);

  localparam int D = bmhq_pkg::FIFO_DEPTH;

  bmhq_pkg::cmd_t fifo_r [D];
  logic [$clog2(D)-1:0] wp_r, rp_r;
  logic [$clog2(D):0]   cnt_r;
  logic push, pop;

  assign in_stall  = (cnt_r == ($clog2(D)+1)'(D));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = fifo_r[rp_r];

  // Store payload of an accepted beat
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= '{op: bmhq_pkg::op_t'(in_opcode), value: in_value};
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{$clog2(D){1'b0}}, push} - {{$clog2(D){1'b0}}, pop};
    end
  end

endmodule

>>> src/bmhq_back.sv
// ----------------------------------------------------------------------------
// bmhq_back
// Sequencer that carries out push, pop and search on the heap RAM.
// ----------------------------------------------------------------------------
module bmhq_back #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_take,
  input  bmhq_pkg::cmd_t     cmd,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [9:0]         out_found_index,
  output logic signed [31:0] out_top_value,
  output logic [10:0]        out_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  bmhq_pkg::state_t state_r, state_nxt;
  bmhq_pkg::cmd_t   cmd_r;
  logic [CW-1:0] n_r;
  logic [AW-1:0] pos_r;
  logic [AW:0]   kid_r;
  logic [31:0]   val_r, lval_r;
  logic [AW:0]   stk_r [AW+1];
  logic [$clog2(AW+2)-1:0] sp_r;
  logic [1:0]    st_r;
  logic [AW-1:0] fidx_r;
  logic [31:0]   top_r;
  logic          ov_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  bmhq_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [AW:0] parent, lkid;
  logic [AW:0] rkid;
  assign parent = ({1'b0, pos_r} - 1'b1) >> 1;
  assign lkid   = {pos_r, 1'b1};
  assign rkid   = kid_r + 1'b1;

  assign cmd_take        = (state_r == bmhq_pkg::S_IDLE) && !ov_r;
  assign out_valid       = ov_r;
  assign out_status      = st_r;
  assign out_found_index = 10'(fidx_r);
  assign out_top_value   = top_r;
  assign out_count       = 11'(n_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bmhq_pkg::S_IDLE: begin
        if (cmd_valid && !ov_r) begin
          case (cmd.op)
            bmhq_pkg::OP_PUSH:
              state_nxt = (n_r == CW'(CAPACITY)) ? bmhq_pkg::S_TOP_RD
                                                 : bmhq_pkg::S_PUSH_RD;
            bmhq_pkg::OP_POP:
              state_nxt = (n_r == '0) ? bmhq_pkg::S_TOP_RD : bmhq_pkg::S_POP_RD_LAST;
            bmhq_pkg::OP_SEARCH:
              state_nxt = (n_r == '0) ? bmhq_pkg::S_TOP_RD : bmhq_pkg::S_SRCH_RD;
            default: state_nxt = bmhq_pkg::S_TOP_RD;
          endcase
        end
      end
      bmhq_pkg::S_PUSH_RD:
        state_nxt = (pos_r == '0) ? bmhq_pkg::S_TOP_RD : bmhq_pkg::S_PUSH_CMP;
      bmhq_pkg::S_PUSH_CMP:
        state_nxt = ($signed(rdata) < $signed(val_r)) ? bmhq_pkg::S_PUSH_RD
                                                      : bmhq_pkg::S_TOP_RD;
      bmhq_pkg::S_POP_RD_LAST: state_nxt = bmhq_pkg::S_POP_WR_ROOT;
      bmhq_pkg::S_POP_WR_ROOT: state_nxt = bmhq_pkg::S_POP_RD_KIDS;
      bmhq_pkg::S_POP_RD_KIDS:
        state_nxt = (lkid < (AW+1)'(n_r)) ? bmhq_pkg::S_POP_WAIT : bmhq_pkg::S_TOP_RD;
      bmhq_pkg::S_POP_WAIT:    state_nxt = bmhq_pkg::S_POP_CMP;
      bmhq_pkg::S_POP_CMP:     state_nxt = bmhq_pkg::S_POP_RD_KIDS;
      bmhq_pkg::S_SRCH_RD:     state_nxt = bmhq_pkg::S_SRCH_CMP;
      bmhq_pkg::S_SRCH_CMP: begin
        // finish on a match, or when no child and no saved subtree is left
        if (rdata == cmd_r.value || (!(lkid < (AW+1)'(n_r)) && sp_r == '0))
          state_nxt = bmhq_pkg::S_TOP_RD;
        else
          state_nxt = bmhq_pkg::S_SRCH_RD;
      end
      bmhq_pkg::S_TOP_RD:  state_nxt = bmhq_pkg::S_TOP_WAIT;
      bmhq_pkg::S_TOP_WAIT: state_nxt = bmhq_pkg::S_IDLE;
      default: state_nxt = bmhq_pkg::S_IDLE;
    endcase
  end

  // Children of the node just compared during search; the right one may be stacked
  logic [AW:0] sl, sr;
  logic [$clog2(AW+2)-1:0] sp_pop;
  logic [$clog2(AW+2)-1:0] sp_nxt;
  logic [AW:0] stop_nxt;
  assign sl     = {pos_r, 1'b1};
  assign sr     = {pos_r, 1'b1} + 1'b1;
  assign sp_pop = sp_r - 1'b1;

  // Pick next preorder node: the left child if valid (stacking the right one when it is valid too), else the stack top
  always_comb begin
    sp_nxt   = sp_r;
    stop_nxt = '0;
    if (sr < (AW+1)'(n_r) && sl < (AW+1)'(n_r)) begin
      stop_nxt = sl;
      sp_nxt   = sp_r + 1'b1;
    end else if (sl < (AW+1)'(n_r)) begin
      stop_nxt = sl;
    end else if (sp_r != '0) begin
      stop_nxt = stk_r[sp_pop];
      sp_nxt   = sp_pop;
    end
  end

  // Outputs to RAM
  always_comb begin
    we    = 1'b0;
    waddr = pos_r;
    wdata = val_r;
    raddr = pos_r;
    case (state_r)
      bmhq_pkg::S_IDLE: begin
        we    = cmd_valid && !ov_r && cmd.op == bmhq_pkg::OP_PUSH &&
                n_r != CW'(CAPACITY);
        waddr = AW'(n_r);
        wdata = cmd.value;
      end
      // park the rising value at its current slot while the parent is read
      bmhq_pkg::S_PUSH_RD: begin
        we    = 1'b1;
        waddr = pos_r;
        wdata = val_r;
        raddr = AW'(parent);
      end
      bmhq_pkg::S_PUSH_CMP: begin
        we    = $signed(rdata) < $signed(val_r);
        waddr = pos_r;
        wdata = rdata;
      end
      bmhq_pkg::S_POP_RD_LAST: raddr = AW'(n_r);
      bmhq_pkg::S_POP_WR_ROOT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = rdata;
      end
      // park the sinking value at its current slot while the left child is read
      bmhq_pkg::S_POP_RD_KIDS: begin
        we    = 1'b1;
        waddr = pos_r;
        wdata = val_r;
        raddr = AW'(lkid);
      end
      bmhq_pkg::S_POP_WAIT:    raddr = AW'(lkid + 1'b1);
      bmhq_pkg::S_POP_CMP: begin
        we    = 1'b1;
        waddr = pos_r;
        wdata = val_r;
        if (rkid < (AW+1)'(n_r) && $signed(lval_r) < $signed(rdata)) begin
          if ($signed(val_r) < $signed(rdata)) wdata = rdata;
        end else if ($signed(val_r) < $signed(lval_r)) begin
          wdata = lval_r;
        end
      end
      bmhq_pkg::S_TOP_RD: raddr = '0;
      default: ;
    endcase
  end

  // Larger child of the sinking value (left on a tie) and whether the value moves down
  logic pop_move;
  logic [31:0] big;
  logic [AW:0] bigi;
  always_comb begin
    if (rkid < (AW+1)'(n_r) && $signed(lval_r) < $signed(rdata)) begin
      big  = rdata;
      bigi = rkid;
    end else begin
      big  = lval_r;
      bigi = kid_r;
    end
    pop_move = $signed(val_r) < $signed(big);
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmhq_pkg::S_IDLE;
      n_r     <= '0;
      ov_r    <= 1'b0;
      sp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (state_r)
        bmhq_pkg::S_IDLE: begin
          if (cmd_valid && !ov_r) begin
            cmd_r  <= cmd;
            st_r   <= bmhq_pkg::ST_OK;
            fidx_r <= '0;
            pos_r  <= AW'(n_r);
            val_r  <= cmd.value;
            sp_r   <= '0;
            case (cmd.op)
              bmhq_pkg::OP_PUSH:
                if (n_r == CW'(CAPACITY)) st_r <= bmhq_pkg::ST_FULL;
                else                      n_r  <= n_r + 1'b1;
              bmhq_pkg::OP_POP:
                if (n_r == '0) st_r <= bmhq_pkg::ST_EMPTY;
                else           n_r  <= n_r - 1'b1;
              bmhq_pkg::OP_SEARCH: begin
                pos_r <= '0;
                if (n_r == '0) st_r <= bmhq_pkg::ST_NOT_FOUND;
              end
              default: ;
            endcase
          end
        end
        bmhq_pkg::S_PUSH_RD: ;
        bmhq_pkg::S_PUSH_CMP: begin
          if ($signed(rdata) < $signed(val_r)) pos_r <= AW'(parent);
          else if (pos_r != '0) ;
        end
        bmhq_pkg::S_POP_WR_ROOT: begin
          val_r <= rdata;
          pos_r <= '0;
        end
        bmhq_pkg::S_POP_RD_KIDS: kid_r <= lkid;
        bmhq_pkg::S_POP_WAIT: lval_r <= rdata;
        bmhq_pkg::S_POP_CMP: begin
          if (pop_move) pos_r <= AW'(bigi);
          else          pos_r <= AW'(n_r);
        end
        bmhq_pkg::S_SRCH_CMP: begin
          if (rdata == cmd_r.value) begin
            fidx_r <= pos_r;
          end else begin
            if (sr < (AW+1)'(n_r) && sl < (AW+1)'(n_r)) stk_r[sp_r] <= sr;
            sp_r  <= sp_nxt;
            pos_r <= AW'(stop_nxt);
            if (sp_nxt == sp_r && !(sl < (AW+1)'(n_r)) && sp_r == '0)
              st_r <= bmhq_pkg::ST_NOT_FOUND;
          end
        end
        bmhq_pkg::S_TOP_WAIT: begin
          top_r <= (n_r == '0) ? '0 : rdata;
          ov_r  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> src/binary_max_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Array-based binary max-heap of signed 32-bit values.
// ----------------------------------------------------------------------------
// Input beats (in_opcode, in_value) carry push, pop or search commands and
// land in a two-entry command queue; a sequencer works them off one at a
// time against a single-port-per-side heap RAM with registered reads.
// Each command yields exactly one output beat with status, found index,
// current maximum and entry count.
// A push sifts its value up level by level, a pop moves the last entry to the
// root and sifts it down, and a search walks the nodes in preorder.
// One command runs at a time; the next starts the cycle after the output
// beat is taken.
// Reset clears the count and all control; RAM contents need no clearing.
// While out_stall is high a pending output beat holds and no new command
// starts; the queue keeps taking input beats until it is full.
module binary_max_heap_queue #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [9:0]         out_found_index,
  output logic signed [31:0] out_top_value,
  output logic [10:0]        out_count
);

  logic           cmd_valid, cmd_take;
  bmhq_pkg::cmd_t cmd;

  bmhq_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_value(in_value),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  bmhq_back #(.CAPACITY(CAPACITY)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
    .cmd(cmd), .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_found_index(out_found_index),
    .out_top_value(out_top_value), .out_count(out_count)
  );

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary max-heap queue: directed edge cases,
// then random push/pop/search traffic on a small heap, a fill to capacity
// and a partial drain. Beats are held to a heap model or typed table rows.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = bmhq_pkg::CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    bmhq_pkg::status_t  st;
    logic [9:0]         idx;
    logic signed [31:0] top;
    logic [10:0]        cnt;
  } heap_res_t;

  typedef struct {
    bmhq_pkg::op_t      op;
    logic signed [31:0] val;
    bit                 typed;
    heap_res_t          res;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_opcode = '0;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic [9:0]         out_found_index;
  logic signed [31:0] out_top_value;
  logic [10:0]        out_count;

  // heap model state
  logic signed [31:0] heap_m [CAP];
  int                 heap_n = 0;

  heap_res_t pending_res_q[$];
  bit        typed_flag_q[$];
  heap_res_t typed_res_q[$];
  int        errors = 0;
  int        cycles = 0;
  bit        quiet = 1'b0;
  bit        long_hold = 1'b0;

  binary_max_heap_queue i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_top_value   (out_top_value),
    .out_count       (out_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // preorder search below pos; -1 when nothing matches
  function automatic int find_preorder(int pos, logic signed [31:0] v);
    int hit;
    if (pos >= heap_n) return -1;
    if (heap_m[pos] == v) return pos;
    hit = find_preorder(2 * pos + 1, v);
    if (hit >= 0) return hit;
    return find_preorder(2 * pos + 2, v);
  endfunction

  // apply one command to the model heap and return the expected beat
  function automatic heap_res_t heap_apply(logic [1:0] op, logic signed [31:0] v);
    heap_res_t          r;
    int                 pos, par, kid, hit;
    logic signed [31:0] tmp;
    r.st = bmhq_pkg::ST_OK;
    r.idx = '0;
    case (op)
      bmhq_pkg::OP_PUSH: begin
        if (heap_n >= CAP) begin
          r.st = bmhq_pkg::ST_FULL;
        end else begin
          heap_m[heap_n] = v;
          pos = heap_n;
          heap_n++;
          while (pos > 0) begin
            par = (pos - 1) / 2;
            if (!(heap_m[par] < heap_m[pos])) break;
            tmp = heap_m[par]; heap_m[par] = heap_m[pos]; heap_m[pos] = tmp;
            pos = par;
          end
        end
      end
      bmhq_pkg::OP_POP: begin
        if (heap_n == 0) begin
          r.st = bmhq_pkg::ST_EMPTY;
        end else begin
          heap_m[0] = heap_m[heap_n - 1];
          heap_n--;
          pos = 0;
          kid = 1;
          while (kid < heap_n) begin
            if (kid + 1 < heap_n && heap_m[kid] < heap_m[kid + 1]) kid++;
            if (!(heap_m[pos] < heap_m[kid])) break;
            tmp = heap_m[pos]; heap_m[pos] = heap_m[kid]; heap_m[kid] = tmp;
            pos = kid;
            kid = 2 * pos + 1;
          end
        end
      end
      bmhq_pkg::OP_SEARCH: begin
        hit = find_preorder(0, v);
        if (hit >= 0) r.idx = hit[9:0];
        else r.st = bmhq_pkg::ST_NOT_FOUND;
      end
      default: ;
    endcase
    r.top = (heap_n > 0) ? heap_m[0] : '0;
    r.cnt = heap_n[10:0];
    return r;
  endfunction

  // compare finished beats, then record accepted commands
  always @(posedge clk) begin
    heap_res_t e, m;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_res_q.size() == 0) begin
          $display("%0t: unexpected beat status=%0d idx=%0d top=%0d count=%0d", $time,
                   out_status, out_found_index, out_top_value, out_count);
          errors++;
        end else begin
          e = pending_res_q.pop_front();
          if (out_status != e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, out_status);
            errors++;
          end
          if (out_found_index != e.idx) begin
            $display("%0t: found_index expected %0d actual %0d", $time, e.idx,
                     out_found_index);
            errors++;
          end
          if (out_top_value != e.top) begin
            $display("%0t: top_value expected %0d actual %0d", $time, e.top,
                     out_top_value);
            errors++;
          end
          if (out_count != e.cnt) begin
            $display("%0t: count expected %0d actual %0d", $time, e.cnt, out_count);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        m = heap_apply(in_opcode, in_value);
        if (typed_flag_q.pop_front()) m = typed_res_q.pop_front();
        pending_res_q = {pending_res_q, m};
      end
    end
  end

  // result side stalls: random bursts and one long hold
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // offer one beat and hold it until taken
  task automatic send_cmd(logic [1:0] op, logic signed [31:0] v, bit typed = 1'b0,
                          heap_res_t r = '0);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    typed_flag_q = {typed_flag_q, typed};
    if (typed) typed_res_q = {typed_res_q, r};
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 1)) return $signed($urandom_range(0, 16)) - 8;
    return $signed($urandom());
  endfunction

  // search for a stored value half the time
  function automatic logic signed [31:0] pick_search();
    if (heap_n > 0 && $urandom_range(0, 1)) return heap_m[$urandom_range(0, heap_n - 1)];
    return pick_value();
  endfunction

  localparam logic signed [31:0] VMAX = 32'sh7fffffff;
  localparam logic signed [31:0] VMIN = 32'sh80000000;

  dir_row_t dir_rows[] = '{
    '{bmhq_pkg::OP_POP,    32'sd5, 1'b1,
      '{bmhq_pkg::ST_EMPTY,     10'd0, 32'sd0, 11'd0}},
    '{bmhq_pkg::OP_SEARCH, 32'sd0, 1'b1,
      '{bmhq_pkg::ST_NOT_FOUND, 10'd0, 32'sd0, 11'd0}},
    '{bmhq_pkg::OP_NONE,   -32'sd1, 1'b1,
      '{bmhq_pkg::ST_OK,        10'd0, 32'sd0, 11'd0}},
    '{bmhq_pkg::OP_PUSH,   VMIN,   1'b1,
      '{bmhq_pkg::ST_OK,        10'd0, VMIN,   11'd1}},
    '{bmhq_pkg::OP_PUSH,   VMAX,   1'b1,
      '{bmhq_pkg::ST_OK,        10'd0, VMAX,   11'd2}},
    '{bmhq_pkg::OP_SEARCH, VMIN,   1'b1,
      '{bmhq_pkg::ST_OK,        10'd1, VMAX,   11'd2}},
    '{bmhq_pkg::OP_SEARCH, VMAX,   1'b1,
      '{bmhq_pkg::ST_OK,        10'd0, VMAX,   11'd2}},
    '{bmhq_pkg::OP_SEARCH, 32'sd7, 1'b1,
      '{bmhq_pkg::ST_NOT_FOUND, 10'd0, VMAX,   11'd2}},
    '{bmhq_pkg::OP_PUSH,   32'sd0, 1'b0, '0},
    '{bmhq_pkg::OP_PUSH,   VMAX,   1'b0, '0},
    '{bmhq_pkg::OP_PUSH,   -32'sd1, 1'b0, '0},
    '{bmhq_pkg::OP_PUSH,   32'sd3, 1'b0, '0},
    '{bmhq_pkg::OP_SEARCH, -32'sd1, 1'b0, '0},
    '{bmhq_pkg::OP_NONE,   VMAX,   1'b0, '0},
    '{bmhq_pkg::OP_POP,    32'sd0, 1'b0, '0},
    '{bmhq_pkg::OP_POP,    32'sd0, 1'b0, '0},
    '{bmhq_pkg::OP_SEARCH, 32'sd3, 1'b0, '0},
    '{bmhq_pkg::OP_POP,    32'sd0, 1'b0, '0},
    '{bmhq_pkg::OP_POP,    32'sd0, 1'b0, '0},
    '{bmhq_pkg::OP_POP,    32'sd0, 1'b0, '0},
    '{bmhq_pkg::OP_POP,    VMIN,   1'b1,
      '{bmhq_pkg::ST_OK,        10'd0, 32'sd0, 11'd0}},
    '{bmhq_pkg::OP_POP,    VMIN,   1'b1,
      '{bmhq_pkg::ST_EMPTY,     10'd0, 32'sd0, 11'd0}}
  };

  initial begin
    int         wait_cyc;
    logic [1:0] op;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) send_cmd(dir_rows[i].op, dir_rows[i].val, dir_rows[i].typed,
                                   dir_rows[i].res);

    // long result hold while input keeps coming
    long_hold = 1'b1;
    for (int i = 0; i < 150; i++) begin
      if (i == 75) begin
        // pause until the block has drained
        in_valid <= 1'b0;
        @(negedge clk);
        wait (pending_res_q.size() == 0);
        @(posedge clk);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: op = (heap_n < 60) ? bmhq_pkg::OP_PUSH : bmhq_pkg::OP_POP;
        4, 5, 6:    op = bmhq_pkg::OP_POP;
        7, 8:       op = bmhq_pkg::OP_SEARCH;
        default:    op = $urandom_range(0, 1) ? bmhq_pkg::OP_NONE : bmhq_pkg::OP_PUSH;
      endcase
      send_cmd(op, (op == bmhq_pkg::OP_SEARCH) ? pick_search() : pick_value());
    end

    // fill to capacity, then push past it
    while (heap_n < CAP) begin
      if ($urandom_range(0, 99) == 0) send_cmd(bmhq_pkg::OP_SEARCH, pick_search());
      else if ($urandom_range(0, 19) == 0) send_cmd(bmhq_pkg::OP_POP, pick_value());
      else send_cmd(bmhq_pkg::OP_PUSH, pick_value());
    end
    repeat (4) send_cmd(bmhq_pkg::OP_PUSH, pick_value());
    send_cmd(bmhq_pkg::OP_SEARCH, pick_search());

    // drain part of the way with no idling
    quiet = 1'b1;
    for (int i = 0; i < 150; i++) begin
      if ($urandom_range(0, 49) == 0) send_cmd(bmhq_pkg::OP_SEARCH, pick_search());
      else send_cmd(bmhq_pkg::OP_POP, pick_value());
    end
    in_valid <= 1'b0;

    @(negedge clk);
    wait (pending_res_q.size() == 0);
    wait_cyc = 0;
    while (wait_cyc < 3000) begin
      @(posedge clk);
      wait_cyc++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/bmhq_pkg.sv
src/bmhq_ram.sv
src/bmhq_front.sv
src/bmhq_back.sv
src/binary_max_heap_queue.sv
sim/tb_top.sv
